@@ sv/urm_pkg.sv @@
// ----------------------------------------------------------------------------
// urm_pkg
// Shared types, field widths and reset values for the ultrasonic range unit.
// ----------------------------------------------------------------------------
package urm_pkg;

    // Field widths
    localparam int TRIG_TICKS_W = 10;
    localparam int WAIT_LIMIT_W = 20;
    localparam int WIDTH_W      = 16;
    localparam int DIST_W       = 21;
    localparam int APB_ADDR_W   = 4;
    localparam int APB_DATA_W   = 32;

    // Default counter widths
    localparam int WAIT_WIDTH_DEF  = 20;
    localparam int COUNT_WIDTH_DEF = 16;

    // Register reset values
    localparam logic [TRIG_TICKS_W-1:0] TRIG_LOW_RST   = 10'd10;
    localparam logic [TRIG_TICKS_W-1:0] TRIG_HIGH_RST  = 10'd20;
    localparam logic [WAIT_LIMIT_W-1:0] WAIT_LIMIT_RST = 20'd500000;
    localparam logic [WIDTH_W-1:0]      TMO_CODE_RST   = 16'hFFFF;

    // Distance scale: thousandths of a centimetre per echo tick
    localparam logic [DIST_W-1:0] CM_FACTOR = 21'd17;

    // Register index within the APB map (address bits [3:2])
    typedef enum logic [1:0] {
        REG_TRIG_LOW   = 2'd0,
        REG_TRIG_HIGH  = 2'd1,
        REG_WAIT_LIMIT = 2'd2,
        REG_TMO_CODE   = 2'd3
    } urm_reg_idx_t;

    typedef struct packed {
        logic [TRIG_TICKS_W-1:0] trig_low;
        logic [TRIG_TICKS_W-1:0] trig_high;
        logic [WAIT_LIMIT_W-1:0] wait_limit;
        logic [WIDTH_W-1:0]      tmo_code;
    } urm_cfg_t;

    typedef struct packed {
        logic               trigger_level;
        logic               busy;
        logic               done;
        logic               timed_out;
        logic [WIDTH_W-1:0] echo_width;
        logic [DIST_W-1:0]  distance;
    } urm_result_t;

endpackage

@@ sv/urm_regs.sv @@
// ----------------------------------------------------------------------------
// urm_regs
// APB configuration registers of the ultrasonic range unit.
// ----------------------------------------------------------------------------
module urm_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [urm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [urm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [urm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output urm_pkg::urm_cfg_t                cfg
);

    urm_pkg::urm_cfg_t    cfg_reg;
    urm_pkg::urm_reg_idx_t idx;
    logic                 wr_en;

    assign pready = 1'b1;
    assign idx    = urm_pkg::urm_reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.trig_low   <= urm_pkg::TRIG_LOW_RST;
            cfg_reg.trig_high  <= urm_pkg::TRIG_HIGH_RST;
            cfg_reg.wait_limit <= urm_pkg::WAIT_LIMIT_RST;
            cfg_reg.tmo_code   <= urm_pkg::TMO_CODE_RST;
        end else if (wr_en) begin
            unique case (idx)
                urm_pkg::REG_TRIG_LOW:
                    cfg_reg.trig_low <= pwdata[urm_pkg::TRIG_TICKS_W-1:0];
                urm_pkg::REG_TRIG_HIGH:
                    cfg_reg.trig_high <= pwdata[urm_pkg::TRIG_TICKS_W-1:0];
                urm_pkg::REG_WAIT_LIMIT:
                    cfg_reg.wait_limit <= pwdata[urm_pkg::WAIT_LIMIT_W-1:0];
                urm_pkg::REG_TMO_CODE:
                    cfg_reg.tmo_code <= pwdata[urm_pkg::WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (idx)
            urm_pkg::REG_TRIG_LOW:
                prdata = urm_pkg::APB_DATA_W'(cfg_reg.trig_low);
            urm_pkg::REG_TRIG_HIGH:
                prdata = urm_pkg::APB_DATA_W'(cfg_reg.trig_high);
            urm_pkg::REG_WAIT_LIMIT:
                prdata = urm_pkg::APB_DATA_W'(cfg_reg.wait_limit);
            urm_pkg::REG_TMO_CODE:
                prdata = urm_pkg::APB_DATA_W'(cfg_reg.tmo_code);
            default: prdata = '0;
        endcase
    end

endmodule

@@ sv/urm_core.sv @@
// ----------------------------------------------------------------------------
// urm_core
// Ranging sequencer: trigger pulse, echo wait and echo width count per tick.
// ----------------------------------------------------------------------------
module urm_core #(
    parameter int WAIT_WIDTH  = urm_pkg::WAIT_WIDTH_DEF,
    parameter int COUNT_WIDTH = urm_pkg::COUNT_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic                  start_req,
    input  logic                  echo_level,
    input  urm_pkg::urm_cfg_t     cfg,
    output urm_pkg::urm_result_t  result
);

    localparam int CMP_W = (WAIT_WIDTH > urm_pkg::WAIT_LIMIT_W) ?
                           WAIT_WIDTH : urm_pkg::WAIT_LIMIT_W;
    localparam int WEXT_W = (COUNT_WIDTH > urm_pkg::WIDTH_W) ?
                            COUNT_WIDTH : urm_pkg::WIDTH_W;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_TLOW  = 3'd1,
        PH_THIGH = 3'd2,
        PH_WAIT  = 3'd3,
        PH_MEAS  = 3'd4
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [WAIT_WIDTH-1:0]  tick_reg, tick_next;
    logic [COUNT_WIDTH-1:0] wcnt_reg, wcnt_next;

    logic [WAIT_WIDTH-1:0]      tick_inc;
    logic [WAIT_WIDTH-1:0]      tick_sat;
    logic [WEXT_W-1:0]          wcnt_ext;
    logic                       trig;
    logic                       done;
    logic                       tmo;
    logic [urm_pkg::WIDTH_W-1:0] width;

    assign tick_inc = tick_reg + WAIT_WIDTH'(1);
    assign tick_sat = (tick_reg != '1) ? tick_inc : tick_reg;
    assign wcnt_ext = WEXT_W'(wcnt_reg);

    always_comb begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        wcnt_next  = wcnt_reg;
        trig       = 1'b0;
        done       = 1'b0;
        tmo        = 1'b0;
        width      = '0;
        unique case (phase_reg)
            PH_IDLE: begin
                if (start_req) begin
                    // the start tick is the first low-trigger tick
                    if (cfg.trig_low <= urm_pkg::TRIG_TICKS_W'(1)) begin
                        phase_next = PH_THIGH;
                        tick_next  = '0;
                    end else begin
                        phase_next = PH_TLOW;
                        tick_next  = WAIT_WIDTH'(1);
                    end
                end
            end
            PH_TLOW: begin
                tick_next = tick_inc;
                if (CMP_W'(tick_inc) >= CMP_W'(cfg.trig_low) || tick_inc == '0) begin
                    phase_next = PH_THIGH;
                    tick_next  = '0;
                end
            end
            PH_THIGH: begin
                trig      = 1'b1;
                tick_next = tick_inc;
                if (CMP_W'(tick_inc) >= CMP_W'(cfg.trig_high) || tick_inc == '0) begin
                    phase_next = PH_WAIT;
                    tick_next  = '0;
                end
            end
            PH_WAIT: begin
                if (echo_level) begin
                    phase_next = PH_MEAS;
                    wcnt_next  = COUNT_WIDTH'(1);
                    tick_next  = '0;
                end else begin
                    tick_next = tick_sat;
                    if (CMP_W'(tick_sat) >= CMP_W'(cfg.wait_limit) || tick_sat == '1) begin
                        done       = 1'b1;
                        tmo        = 1'b1;
                        width      = cfg.tmo_code;
                        phase_next = PH_IDLE;
                        tick_next  = '0;
                        wcnt_next  = '0;
                    end
                end
            end
            PH_MEAS: begin
                if (echo_level) begin
                    // saturate on a long echo
                    if (wcnt_reg != '1) begin
                        wcnt_next = wcnt_reg + COUNT_WIDTH'(1);
                    end
                end else begin
                    done       = 1'b1;
                    width      = wcnt_ext[urm_pkg::WIDTH_W-1:0];
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                    wcnt_next  = '0;
                end
            end
            default: begin
                phase_next = PH_IDLE;
                tick_next  = '0;
                wcnt_next  = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            wcnt_reg  <= '0;
        end else if (advance) begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            wcnt_reg  <= wcnt_next;
        end
    end

    always_comb begin
        result.trigger_level = trig;
        result.busy          = (phase_next != PH_IDLE);
        result.done          = done;
        result.timed_out     = tmo;
        result.echo_width    = width;
        result.distance      = urm_pkg::DIST_W'(width) * urm_pkg::CM_FACTOR;
    end

    // a measurement in progress never goes back to idle without a done word
    a_idle_only_via_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && phase_reg != PH_IDLE && phase_next == PH_IDLE &&
         phase_reg != PH_TLOW && phase_reg != PH_THIGH) |-> done)
        else $error("urm_core: left measurement without done");

    a_counter_clear_in_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) |-> (wcnt_reg == '0))
        else $error("urm_core: width counter not clear in idle");

    a_meas_counts_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_MEAS) |-> (wcnt_reg != '0))
        else $error("urm_core: zero width counter while measuring");

endmodule

@@ sv/urm_out_reg.sv @@
// ----------------------------------------------------------------------------
// urm_out_reg
// Result register with valid/ready hand-off; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module urm_out_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  urm_pkg::urm_result_t data_in,
    input  logic                 m_ready,
    output logic                 m_valid,
    output logic                 can_load,
    output urm_pkg::urm_result_t data_out
);

    logic                 valid_reg, valid_next;
    urm_pkg::urm_result_t data_reg;

    assign can_load   = !valid_reg || m_ready;
    assign valid_next = load ? 1'b1 : (valid_reg && !m_ready);
    assign m_valid    = valid_reg;
    assign data_out   = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_in;
        end
    end

endmodule

@@ sv/ultrasonic_range_measure_unit.sv @@
// ----------------------------------------------------------------------------
// ultrasonic_range_measure_unit
// A tick word is accepted and its result word shows on m_* in the cycle after.
// Throughput: one tick word per cycle unless m_ready stalls; the single result register
// refills as it drains. Rate is set by the sequencer update between the state
// and result registers. Reset (aresetn low, synchronous): sequencer idle, counters
// cleared, no result held, configuration registers back to their default values.
// ----------------------------------------------------------------------------
module ultrasonic_range_measure_unit #(
    parameter int WAIT_WIDTH  = urm_pkg::WAIT_WIDTH_DEF,
    parameter int COUNT_WIDTH = urm_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [urm_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [urm_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [urm_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,

    // tick words in
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_start_req,
    input  logic                              s_echo_level,

    // result words out
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_trigger_level,
    output logic                              m_busy_res,
    output logic                              m_done_res,
    output logic                              m_timed_out,
    output logic [urm_pkg::WIDTH_W-1:0]       m_echo_width,
    output logic [urm_pkg::DIST_W-1:0]        m_distance
);

    urm_pkg::urm_cfg_t    cfg;
    urm_pkg::urm_result_t core_res;
    urm_pkg::urm_result_t out_res;
    logic                 accept;

    // Accept a tick word whenever the result register is empty or draining.
    assign accept = s_valid && s_ready;

    urm_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Advance the sequencer state only on an accepted tick; its result
    // word for that tick is formed in the same cycle.
    urm_core #(
        .WAIT_WIDTH  (WAIT_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (accept),
        .start_req  (s_start_req),
        .echo_level (s_echo_level),
        .cfg        (cfg),
        .result     (core_res)
    );

    // Hold the result word until the consumer takes it.
    urm_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .data_in  (core_res),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .can_load (s_ready),
        .data_out (out_res)
    );

    assign m_trigger_level = out_res.trigger_level;
    assign m_busy_res      = out_res.busy;
    assign m_done_res      = out_res.done;
    assign m_timed_out     = out_res.timed_out;
    assign m_echo_width    = out_res.echo_width;
    assign m_distance      = out_res.distance;

    // every accepted tick yields a result word in the next cycle
    a_accept_gives_word: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("unit: accepted tick produced no result word");

    // timeout is only reported with done, and a finished measurement is not busy
    a_timeout_with_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_timed_out) |-> (m_done_res && !m_busy_res))
        else $error("unit: timeout flag without done");

    // width and distance are zero on words that do not finish a measurement
    a_quiet_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_done_res) |-> (m_echo_width == '0 && m_distance == '0))
        else $error("unit: width or distance set without done");

    // distance tracks the reported width
    a_distance_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_distance == urm_pkg::DIST_W'(m_echo_width) * urm_pkg::CM_FACTOR))
        else $error("unit: distance does not match echo width");

endmodule
